FILE: hdl/swdb_pkg.sv
package swdb_pkg;

  // Widths fixed by the interface
  localparam int NOW_BITS       = 32;
  localparam int OUT_BITS       = 32;
  localparam int THRESH_BITS    = 16;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam int TIME_BITS_DFLT = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ACTIVE_HIGH  = 2'd0;
  localparam logic [1:0] REG_MIN_ON_TIME  = 2'd1;
  localparam logic [1:0] REG_MIN_OFF_TIME = 2'd2;

  // Debouncer phases
  localparam logic [1:0] PH_RELEASED     = 2'd0;
  localparam logic [1:0] PH_PEND_PRESS   = 2'd1;
  localparam logic [1:0] PH_PRESSED      = 2'd2;
  localparam logic [1:0] PH_PEND_RELEASE = 2'd3;

  // Register reset values
  localparam logic                   ACTIVE_HIGH_RST = 1'b0;
  localparam logic [THRESH_BITS-1:0] MIN_ON_RST      = 16'd30;
  localparam logic [THRESH_BITS-1:0] MIN_OFF_RST     = 16'd30;

  typedef struct packed {
    logic                   active_high;
    logic [THRESH_BITS-1:0] min_on_time;
    logic [THRESH_BITS-1:0] min_off_time;
  } cfg_t;

endpackage

FILE: hdl/swdb_cfg.sv
module swdb_cfg
  import swdb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high  <= ACTIVE_HIGH_RST;
      cfg.min_on_time  <= MIN_ON_RST;
      cfg.min_off_time <= MIN_OFF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACTIVE_HIGH:  cfg.active_high  <= pwdata[0];
        REG_MIN_ON_TIME:  cfg.min_on_time  <= pwdata[THRESH_BITS-1:0];
        REG_MIN_OFF_TIME: cfg.min_off_time <= pwdata[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_HIGH:
        prdata = {{(CFG_DATA_BITS-1){1'b0}}, cfg.active_high};
      REG_MIN_ON_TIME:
        prdata = {{(CFG_DATA_BITS-THRESH_BITS){1'b0}}, cfg.min_on_time};
      REG_MIN_OFF_TIME:
        prdata = {{(CFG_DATA_BITS-THRESH_BITS){1'b0}}, cfg.min_off_time};
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: hdl/switch_debounce_with_durations.sv
// Switch debouncer with press and release durations. Each transfer carries
// one pin sample and the current millisecond time; each sample yields one
// result with the debounced state, one-sample edge flags and the length of
// the current or last press and release (differences wrap modulo
// 2^TIME_BITS, outputs show the low 32 bits). One sample is accepted every
// clock while the output is not stalled; its result passes through the input
// register, then the result register that also holds the debouncer state.
// in_stall follows out_stall in the same cycle when both registers are full.
// Thresholds and the pin polarity come from the APB registers at 0x0, 0x4,
// 0x8 and should be written while no sample is in flight.
module switch_debounce_with_durations
  import swdb_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DFLT
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // samples
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     pin_level,
  input  logic [NOW_BITS-1:0]      now_ms,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     debounced,
  output logic                     rising_edge,
  output logic                     falling_edge,
  output logic [OUT_BITS-1:0]      pressed_ms,
  output logic [OUT_BITS-1:0]      released_ms
);

  cfg_t cfg;

  swdb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Time input and length outputs at TIME_BITS
  logic [TIME_BITS-1:0] now_ext;
  logic [TIME_BITS-1:0] press_length;
  logic [TIME_BITS-1:0] release_length;

  if (TIME_BITS >= NOW_BITS) begin : g_wide
    if (TIME_BITS > NOW_BITS) begin : g_ext
      assign now_ext = {{(TIME_BITS-NOW_BITS){1'b0}}, now_ms};
    end else begin : g_same
      assign now_ext = now_ms;
    end
    assign pressed_ms  = press_length[OUT_BITS-1:0];
    assign released_ms = release_length[OUT_BITS-1:0];
  end else begin : g_narrow
    assign now_ext     = now_ms[TIME_BITS-1:0];
    assign pressed_ms  = {{(OUT_BITS-TIME_BITS){1'b0}}, press_length};
    assign released_ms = {{(OUT_BITS-TIME_BITS){1'b0}}, release_length};
  end

  // Input register
  logic                 s_valid;
  logic                 s_pin;
  logic [TIME_BITS-1:0] s_now;
  logic                 adv;

  assign adv      = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!in_stall) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_pin <= pin_level;
      s_now <= now_ext;
    end
  end

  // Debouncer state; the flags and lengths are the result register
  logic [1:0]           phase, phase_next;
  logic [TIME_BITS-1:0] press_stamp, press_stamp_next;
  logic [TIME_BITS-1:0] release_stamp, release_stamp_next;
  logic                 level_flag, level_flag_next;
  logic                 rise_flag, rise_flag_next;
  logic                 fall_flag, fall_flag_next;
  logic [TIME_BITS-1:0] press_length_next;
  logic [TIME_BITS-1:0] release_length_next;

  logic                 active;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_release;
  logic [TIME_BITS-1:0] stamp_gap;
  logic                 on_done;
  logic                 off_done;

  assign active        = (s_pin == cfg.active_high);
  assign since_press   = s_now - press_stamp;
  assign since_release = s_now - release_stamp;
  assign stamp_gap     = press_stamp - release_stamp;
  assign on_done  = since_press >
                    {{(TIME_BITS-THRESH_BITS){1'b0}}, cfg.min_on_time};
  assign off_done = since_release >
                    {{(TIME_BITS-THRESH_BITS){1'b0}}, cfg.min_off_time};

  // Next-state update for the sample in the input register
  always_comb begin
    phase_next          = phase;
    press_stamp_next    = press_stamp;
    release_stamp_next  = release_stamp;
    level_flag_next     = level_flag;
    rise_flag_next      = rise_flag;
    fall_flag_next      = fall_flag;
    press_length_next   = press_length;
    release_length_next = release_length;
    unique case (phase)
      PH_RELEASED: begin
        fall_flag_next = 1'b0;
        if (active) begin
          phase_next       = PH_PEND_PRESS;
          press_stamp_next = s_now;
        end else begin
          release_length_next = since_release;
        end
      end
      PH_PEND_PRESS: begin
        if (!active) begin
          phase_next = PH_RELEASED;
        end else if (on_done) begin
          phase_next          = PH_PRESSED;
          level_flag_next     = 1'b1;
          rise_flag_next      = 1'b1;
          release_length_next = stamp_gap;
          press_length_next   = since_press;
        end
      end
      PH_PRESSED: begin
        rise_flag_next = 1'b0;
        if (!active) begin
          phase_next         = PH_PEND_RELEASE;
          release_stamp_next = s_now;
        end else begin
          press_length_next = since_press;
        end
      end
      PH_PEND_RELEASE: begin
        if (active) begin
          phase_next = PH_PRESSED;
        end else if (off_done) begin
          phase_next      = PH_RELEASED;
          level_flag_next = 1'b0;
          fall_flag_next  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RELEASED;
      press_stamp    <= '0;
      release_stamp  <= '0;
      level_flag     <= 1'b0;
      rise_flag      <= 1'b0;
      fall_flag      <= 1'b0;
      press_length   <= '0;
      release_length <= '0;
    end else if (adv) begin
      phase          <= phase_next;
      press_stamp    <= press_stamp_next;
      release_stamp  <= release_stamp_next;
      level_flag     <= level_flag_next;
      rise_flag      <= rise_flag_next;
      fall_flag      <= fall_flag_next;
      press_length   <= press_length_next;
      release_length <= release_length_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign debounced    = level_flag;
  assign rising_edge  = rise_flag;
  assign falling_edge = fall_flag;

  // Checks
  a_phase_level: assert property (@(posedge clk) disable iff (rst)
    phase[1] == level_flag)
    else $error("debounced level out of step with phase");

  a_edge_dir: assert property (@(posedge clk) disable iff (rst)
    (!rise_flag || level_flag) && (!fall_flag || !level_flag))
    else $error("edge flag disagrees with debounced level");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(phase) && $stable(press_stamp) && $stable(release_stamp))
    else $error("debouncer state moved without a transfer");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

endmodule
